@@ design/utd_pkg.sv @@
package utd_pkg;

    // Width of the byte and character counters reported at end of string.
    localparam int COUNT_BITS = 10;
    localparam int LIMIT_BITS = 10;
    localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Depth of the queue between the classifier and the decoder.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'h003F;

    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_LEAD2 = 2'd1,
        CLS_LEAD3 = 2'd2,
        CLS_OTHER = 2'd3
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [15:0]           code_unit;
        logic                  has_char;
        logic                  end_of_string;
        logic [COUNT_BITS-1:0] bytes_consumed;
        logic [COUNT_BITS-1:0] chars_out;
    } result_t;

endpackage

@@ design/utd_front.sv @@
module utd_front (
    input  logic          push,
    input  logic [7:0]    in_byte,
    input  logic          is_last,
    input  logic          q_full,
    output logic          q_wr,
    output utd_pkg::item_t q_item
);
    import utd_pkg::*;

    byte_class_t cls;

    // The lead-byte class is only a hint: the decoder ignores it while a
    // sequence is still collecting continuation bytes.
    always_comb
    begin
        if ((in_byte & ASCII_MASK) == 8'h00)
        begin
            cls = CLS_ASCII;
        end
        else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
        begin
            cls = CLS_LEAD2;
        end
        else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
        begin
            cls = CLS_LEAD3;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    assign q_wr        = push && !q_full;
    assign q_item.cls  = cls;
    assign q_item.data = in_byte;
    assign q_item.last = is_last;

endmodule

@@ design/utd_queue.sv @@
module utd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  utd_pkg::item_t wr_item,
    output logic           full,
    input  logic           rd,
    output logic           rd_valid,
    output utd_pkg::item_t rd_item
);
    import utd_pkg::*;

    item_t                     slot_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_next;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_next;
    logic [QUEUE_IDX_BITS:0]   count_reg;
    logic [QUEUE_IDX_BITS:0]   count_next;
    logic                      do_wr;
    logic                      do_rd;

    assign full     = (count_reg == (QUEUE_IDX_BITS+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];

    assign do_wr = wr && !full;
    assign do_rd = rd && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ design/utd_back.sv @@
module utd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr,
    input  logic [utd_pkg::LIMIT_BITS-1:0]   cfg_data,
    input  logic                             q_valid,
    input  utd_pkg::item_t                   q_item,
    output logic                             q_rd,
    input  logic                             pop,
    output logic                             empty,
    output utd_pkg::result_t                 result
);
    import utd_pkg::*;

    logic [LIMIT_BITS-1:0] char_limit_reg;
    logic [1:0]            pending_reg;
    logic [1:0]            pending_next;
    logic [15:0]           partial_reg;
    logic [15:0]           partial_next;
    logic [COUNT_BITS-1:0] char_cnt_reg;
    logic [COUNT_BITS-1:0] char_cnt_next;
    logic [COUNT_BITS-1:0] byte_cnt_reg;
    logic [COUNT_BITS-1:0] byte_cnt_next;
    logic                  limit_hit_reg;
    logic                  limit_hit_next;

    // Two-entry result buffer so decoding continues while a result waits.
    result_t               rbuf_reg [2];
    logic                  rbuf_wr_ptr_reg;
    logic                  rbuf_rd_ptr_reg;
    logic [1:0]            rbuf_count_reg;
    logic [1:0]            rbuf_count_next;
    logic                  rbuf_wr;
    logic                  rbuf_rd;

    logic                  take;
    logic                  emit;
    logic [15:0]           cu;
    logic [1:0]            fill;
    logic [COUNT_BITS+1:0] byte_sum;
    logic [COUNT_BITS:0]   char_sum;
    logic [COUNT_BITS-1:0] byte_new;
    logic [COUNT_BITS-1:0] char_new;
    result_t               res;

    assign take    = q_valid && (rbuf_count_reg != 2'd2);
    assign q_rd    = take;
    assign empty   = (rbuf_count_reg == 2'd0);
    assign result  = rbuf_reg[rbuf_rd_ptr_reg];
    assign rbuf_rd = pop && !empty;

    always_comb
    begin
        emit         = 1'b0;
        cu           = '0;
        fill         = 2'd0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        byte_new     = byte_cnt_reg;
        char_new     = char_cnt_reg;
        byte_sum     = '0;
        char_sum     = '0;
        limit_hit_next = limit_hit_reg;

        if (!limit_hit_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                partial_next = {partial_reg[9:0], q_item.data[5:0]};
                pending_next = pending_reg - 2'd1;
                if (pending_next == 2'd0)
                begin
                    emit = 1'b1;
                    cu   = partial_next;
                end
            end
            else
            begin
                case (q_item.cls)
                    CLS_ASCII:
                    begin
                        emit = 1'b1;
                        cu   = {8'h00, q_item.data};
                    end
                    CLS_LEAD2:
                    begin
                        partial_next = {11'd0, q_item.data[4:0]};
                        pending_next = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        partial_next = {12'd0, q_item.data[3:0]};
                        pending_next = 2'd2;
                    end
                    default:
                    begin
                        emit = 1'b1;
                        cu   = REPLACEMENT_CHAR;
                    end
                endcase
            end

            // A string that ends mid-sequence gets its missing bits as zero
            // and its missing bytes counted.
            if (q_item.last && (pending_next != 2'd0))
            begin
                fill = pending_next;
                cu   = (pending_next == 2'd1) ? {partial_next[9:0], 6'd0}
                                              : {partial_next[3:0], 12'd0};
                pending_next = 2'd0;
                emit = 1'b1;
            end

            byte_sum = {2'b00, byte_cnt_reg} + (COUNT_BITS+2)'(1)
                     + {COUNT_BITS'(0), fill};
            byte_new = (byte_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                       : byte_sum[COUNT_BITS-1:0];

            if (emit)
            begin
                char_sum = {1'b0, char_cnt_reg} + (COUNT_BITS+1)'(1);
                char_new = char_sum[COUNT_BITS] ? COUNT_MAX : char_sum[COUNT_BITS-1:0];
                if ((char_limit_reg != '0) &&
                    (CMP_BITS'(char_new) >= CMP_BITS'(char_limit_reg)))
                begin
                    limit_hit_next = 1'b1;
                end
            end
        end

        res.code_unit      = emit ? cu : 16'h0000;
        res.has_char       = emit;
        res.end_of_string  = q_item.last;
        res.bytes_consumed = q_item.last ? byte_new : '0;
        res.chars_out      = q_item.last ? char_new : '0;

        rbuf_wr = take && (emit || q_item.last);

        byte_cnt_next = byte_new;
        char_cnt_next = char_new;
        if (q_item.last)
        begin
            pending_next   = 2'd0;
            partial_next   = '0;
            byte_cnt_next  = '0;
            char_cnt_next  = '0;
            limit_hit_next = 1'b0;
        end

        rbuf_count_next = rbuf_count_reg;
        if (rbuf_wr && !rbuf_rd)
        begin
            rbuf_count_next = rbuf_count_reg + 2'd1;
        end
        else if (rbuf_rd && !rbuf_wr)
        begin
            rbuf_count_next = rbuf_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg  <= '0;
            pending_reg     <= '0;
            partial_reg     <= '0;
            char_cnt_reg    <= '0;
            byte_cnt_reg    <= '0;
            limit_hit_reg   <= 1'b0;
            rbuf_wr_ptr_reg <= 1'b0;
            rbuf_rd_ptr_reg <= 1'b0;
            rbuf_count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                char_limit_reg <= cfg_data;
            end
            if (take)
            begin
                pending_reg   <= pending_next;
                partial_reg   <= partial_next;
                char_cnt_reg  <= char_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                limit_hit_reg <= limit_hit_next;
            end
            if (rbuf_wr)
            begin
                rbuf_wr_ptr_reg <= !rbuf_wr_ptr_reg;
            end
            if (rbuf_rd)
            begin
                rbuf_rd_ptr_reg <= !rbuf_rd_ptr_reg;
            end
            rbuf_count_reg <= rbuf_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rbuf_wr)
        begin
            rbuf_reg[rbuf_wr_ptr_reg] <= res;
        end
    end

endmodule

@@ design/utf8_to_ucs2_decoder.sv @@
// Streaming UTF-8 to UCS-2 decoder. Bytes are pushed one per transfer with
// is_last marking the final byte of a string; one-, two- and three-byte
// sequences become 16-bit code units, and any other lead byte yields '?'.
// The block takes one byte per clock cycle while full is low: a classifier
// feeds a four-entry queue, which the decoder drains one byte per cycle,
// while its two-entry result buffer has room, into that buffer. The result
// on the final byte carries end_of_string with the saturating byte and
// character counts, and the decoder then starts the next string from a
// clean state. char_limit, written over the cfg channel, caps the code
// units per string (zero means no cap); bytes past the cap are dropped.
// Write it only while the block is idle; the block does not check this.
module utf8_to_ucs2_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     in_byte,
    input  logic                           is_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [15:0]                    code_unit,
    output logic                           has_char,
    output logic                           end_of_string,
    output logic [utd_pkg::COUNT_BITS-1:0] bytes_consumed,
    output logic [utd_pkg::COUNT_BITS-1:0] chars_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [utd_pkg::LIMIT_BITS-1:0] cfg_data
);
    import utd_pkg::*;

    logic    q_wr;
    item_t   q_wr_item;
    logic    q_full;
    logic    q_rd;
    logic    q_valid;
    item_t   q_rd_item;
    result_t res;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    utd_front u_front (
        .push    (push),
        .in_byte (in_byte),
        .is_last (is_last),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_item  (q_wr_item)
    );

    utd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_item  (q_wr_item),
        .full     (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_item  (q_rd_item)
    );

    utd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_item   (q_rd_item),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .result   (res)
    );

    assign code_unit      = res.code_unit;
    assign has_char       = res.has_char;
    assign end_of_string  = res.end_of_string;
    assign bytes_consumed = res.bytes_consumed;
    assign chars_out      = res.chars_out;

endmodule
